// ===== sv/dhkg_pkg.sv =====
// Shared types for the Diffie-Hellman key generation block.
package dhkg_pkg;

    // Status of the shared modular multiplier as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// ===== sv/dhkg_modmul.sv =====
// Bit-serial interleaved modular multiplier: result = a * b mod m, one bit of a per cycle.
module dhkg_modmul #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [VALUE_WIDTH-1:0]   op_a,
    input  logic [VALUE_WIDTH-1:0]   op_b,
    input  logic [VALUE_WIDTH-1:0]   op_m,
    output logic [VALUE_WIDTH-1:0]   result,
    output dhkg_pkg::mm_status_t     status
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] a_reg, a_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    logic [VALUE_WIDTH-1:0] m_reg, m_next;
    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [VALUE_WIDTH:0]   dbl;
    logic [VALUE_WIDTH:0]   m_ext;
    logic [VALUE_WIDTH:0]   dbl_red;
    logic [VALUE_WIDTH:0]   sum;
    logic [VALUE_WIDTH:0]   sum_red;

    // The remainder stays below m, so doubling it or adding b (b < m)
    // needs at most one subtraction of m to come back into range.
    always_comb begin
        m_ext   = {1'b0, m_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (a_reg[VALUE_WIDTH-1] ? {1'b0, b_reg} : '0);
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            a_next    = op_a;
            b_next    = op_b;
            m_next    = op_m;
            r_next    = '0;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            a_next   = {a_reg[VALUE_WIDTH-2:0], 1'b0};
            r_next   = sum_red[VALUE_WIDTH-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    assign result      = r_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== sv/diffie_hellman_key_generation.sv =====
// Top level of the Diffie-Hellman key generation block: sequencer, result register, checks.
//
// One transaction on the slave side carries a modulus, a generator and two secret
// exponents; one transaction on the master side returns both public values and both
// shared keys. All arithmetic runs through a single bit-serial modular multiplier.
// The generator is first reduced modulo the modulus (one product), then four
// square-and-multiply exponentiations run one after another, scanning each exponent
// from its lowest bit: a zero bit costs one square, a one bit a multiply and a square,
// plus one decision step per bit, so short exponents finish sooner. A modulus below
// two is answered with all-zero results without using the multiplier. The block takes
// one item at a time and is not ready while it works, but it accepts the next
// transaction while a finished result still waits in the output register.
module diffie_hellman_key_generation #(
    parameter int VALUE_WIDTH = 16,
    localparam int TDATA_W = ((4 * VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Fields from bit 0 up: modulus, generator, secret_first, secret_second.
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    // Fields from bit 0 up: public_first, public_second, shared_first, shared_second.
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tvalid,
    input  logic               m_tready
);

    localparam int W = VALUE_WIDTH;

    // Sequencer states.
    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_RED_GO   = 9'b000000010,
        ST_RED_WAIT = 9'b000000100,
        ST_LOAD     = 9'b000001000,
        ST_STEP     = 9'b000010000,
        ST_MUL_WAIT = 9'b000100000,
        ST_SQR_WAIT = 9'b001000000,
        ST_STORE    = 9'b010000000,
        ST_OUT      = 9'b100000000
    } state_t;

    // Which of the four exponentiations is running.
    typedef enum logic [1:0] {
        PH_PUB_FIRST  = 2'd0,
        PH_PUB_SECOND = 2'd1,
        PH_SH_FIRST   = 2'd2,
        PH_SH_SECOND  = 2'd3
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [W-1:0] mod_reg, mod_next;
    logic [W-1:0] gen_reg, gen_next;
    logic [W-1:0] s1_reg, s1_next;
    logic [W-1:0] s2_reg, s2_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] sq_reg, sq_next;
    logic [W-1:0] exp_reg, exp_next;
    logic [W-1:0] pub_a_reg, pub_a_next;
    logic [W-1:0] pub_b_reg, pub_b_next;
    logic [W-1:0] sh_a_reg, sh_a_next;
    logic [W-1:0] sh_b_reg, sh_b_next;

    logic [TDATA_W-1:0] m_tdata_reg;
    logic               m_tvalid_reg;

    logic                 mm_start;
    logic [W-1:0]         mm_a;
    logic [W-1:0]         mm_b;
    logic [W-1:0]         mm_result;
    dhkg_pkg::mm_status_t mm_st;

    logic [W-1:0] in_mod;
    logic [W-1:0] in_gen;
    logic [W-1:0] in_s1;
    logic [W-1:0] in_s2;
    logic         out_load;

    assign in_mod = s_tdata[W-1:0];
    assign in_gen = s_tdata[2*W-1:W];
    assign in_s1  = s_tdata[3*W-1:2*W];
    assign in_s2  = s_tdata[4*W-1:3*W];

    // The only arithmetic unit; its operands are steered by the sequencer.
    dhkg_modmul #(
        .VALUE_WIDTH(W)
    ) u_modmul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mm_start),
        .op_a   (mm_a),
        .op_b   (mm_b),
        .op_m   (mod_reg),
        .result (mm_result),
        .status (mm_st)
    );

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        mod_next   = mod_reg;
        gen_next   = gen_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        pub_a_next = pub_a_reg;
        pub_b_next = pub_b_reg;
        sh_a_next  = sh_a_reg;
        sh_b_next  = sh_b_reg;
        mm_start   = 1'b0;
        mm_a       = '0;
        mm_b       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mod_next = in_mod;
                    gen_next = in_gen;
                    s1_next  = in_s1;
                    s2_next  = in_s2;
                    // A modulus of zero or one has no meaningful residues: all zeros.
                    if (in_mod[W-1:1] == '0) begin
                        pub_a_next = '0;
                        pub_b_next = '0;
                        sh_a_next  = '0;
                        sh_b_next  = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_RED_GO;
                    end
                end
            end
            ST_RED_GO: begin
                // Generator times one reduces the generator modulo the modulus.
                mm_start   = 1'b1;
                mm_a       = gen_reg;
                mm_b       = {{(W-1){1'b0}}, 1'b1};
                state_next = ST_RED_WAIT;
            end
            ST_RED_WAIT: begin
                if (mm_st.done) begin
                    gen_next   = mm_result;
                    phase_next = PH_PUB_FIRST;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                acc_next = {{(W-1){1'b0}}, 1'b1};
                case (phase_reg)
                    PH_PUB_FIRST: begin
                        sq_next  = gen_reg;
                        exp_next = s1_reg;
                    end
                    PH_PUB_SECOND: begin
                        sq_next  = gen_reg;
                        exp_next = s2_reg;
                    end
                    PH_SH_FIRST: begin
                        sq_next  = pub_b_reg;
                        exp_next = s1_reg;
                    end
                    PH_SH_SECOND: begin
                        sq_next  = pub_a_reg;
                        exp_next = s2_reg;
                    end
                    default: begin
                        sq_next  = gen_reg;
                        exp_next = s1_reg;
                    end
                endcase
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (exp_reg == '0) begin
                    state_next = ST_STORE;
                end else if (exp_reg[0]) begin
                    mm_start   = 1'b1;
                    mm_a       = acc_reg;
                    mm_b       = sq_reg;
                    state_next = ST_MUL_WAIT;
                end else begin
                    mm_start   = 1'b1;
                    mm_a       = sq_reg;
                    mm_b       = sq_reg;
                    state_next = ST_SQR_WAIT;
                end
            end
            ST_MUL_WAIT: begin
                if (mm_st.done) begin
                    acc_next   = mm_result;
                    mm_start   = 1'b1;
                    mm_a       = sq_reg;
                    mm_b       = sq_reg;
                    state_next = ST_SQR_WAIT;
                end
            end
            ST_SQR_WAIT: begin
                if (mm_st.done) begin
                    sq_next    = mm_result;
                    exp_next   = {1'b0, exp_reg[W-1:1]};
                    state_next = ST_STEP;
                end
            end
            ST_STORE: begin
                case (phase_reg)
                    PH_PUB_FIRST: begin
                        pub_a_next = acc_reg;
                        phase_next = PH_PUB_SECOND;
                        state_next = ST_LOAD;
                    end
                    PH_PUB_SECOND: begin
                        pub_b_next = acc_reg;
                        phase_next = PH_SH_FIRST;
                        state_next = ST_LOAD;
                    end
                    PH_SH_FIRST: begin
                        sh_a_next  = acc_reg;
                        phase_next = PH_SH_SECOND;
                        state_next = ST_LOAD;
                    end
                    PH_SH_SECOND: begin
                        sh_b_next  = acc_reg;
                        state_next = ST_OUT;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result moves into the output register once that register is free.
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_PUB_FIRST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (out_load) begin
            m_tdata_reg <= TDATA_W'({sh_b_reg, sh_a_reg, pub_b_reg, pub_a_reg});
        end
        mod_reg   <= mod_next;
        gen_reg   <= gen_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        exp_reg   <= exp_next;
        pub_a_reg <= pub_a_next;
        pub_b_reg <= pub_b_next;
        sh_a_reg  <= sh_a_next;
        sh_b_reg  <= sh_b_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // The multiplier is only started when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mm_start |-> !mm_st.busy)
        else $error("multiplier started while busy");

    // A finished product is only ever presented while the sequencer waits for one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mm_st.done |-> (state_reg == ST_RED_WAIT || state_reg == ST_MUL_WAIT ||
                        state_reg == ST_SQR_WAIT))
        else $error("multiplier result arrived outside a wait state");

    // Operands fed to the multiplier must already be reduced below the modulus.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (acc_reg < mod_reg && sq_reg < mod_reg))
        else $error("exponentiation operand not reduced");

    // An accepted item always leaves the idle state on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted transaction was dropped");

endmodule

// ===== tb/dhkg_key_checker.sv =====
// Checker for the Diffie-Hellman key generation block: predicts and compares key sets.
`timescale 1ns / 100ps

module dhkg_key_checker #(
    parameter int VALUE_WIDTH = 16,
    localparam int TDATA_W = ((4 * VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    output int                 mismatches,
    output int                 outstanding
);

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        value_t shared_second;
        value_t shared_first;
        value_t public_second;
        value_t public_first;
    } key_set_t;

    key_set_t pending_keys[$];

    // Square-and-multiply with double-width products so nothing overflows.
    function automatic value_t power_mod(input value_t base, input value_t exponent,
                                         input value_t modulus);
        logic [2*VALUE_WIDTH-1:0] acc;
        logic [2*VALUE_WIDTH-1:0] square;
        value_t                   bits_left;
        acc       = (2*VALUE_WIDTH)'(1 % modulus);
        square    = {{VALUE_WIDTH{1'b0}}, value_t'(base % modulus)};
        bits_left = exponent;
        while (bits_left != 0) begin
            if (bits_left[0]) begin
                acc = (acc * square) % modulus;
            end
            square    = (square * square) % modulus;
            bits_left = bits_left >> 1;
        end
        return acc[VALUE_WIDTH-1:0];
    endfunction

    function automatic key_set_t derive_keys(input logic [TDATA_W-1:0] request);
        value_t   modulus;
        value_t   generator;
        value_t   secret_first;
        value_t   secret_second;
        key_set_t keys;
        modulus       = request[0*VALUE_WIDTH +: VALUE_WIDTH];
        generator     = request[1*VALUE_WIDTH +: VALUE_WIDTH];
        secret_first  = request[2*VALUE_WIDTH +: VALUE_WIDTH];
        secret_second = request[3*VALUE_WIDTH +: VALUE_WIDTH];
        keys = '0;
        // A modulus of zero or one yields an all-zero key set.
        if (modulus >= 2) begin
            generator          = generator % modulus;
            keys.public_first  = power_mod(generator, secret_first, modulus);
            keys.public_second = power_mod(generator, secret_second, modulus);
            keys.shared_first  = power_mod(keys.public_second, secret_first, modulus);
            keys.shared_second = power_mod(keys.public_first, secret_second, modulus);
        end
        return keys;
    endfunction

    task automatic compare_field(input string field, input value_t want, input value_t got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        key_set_t want;
        key_set_t got;
        if (!aresetn) begin
            pending_keys.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_keys.push_back(derive_keys(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[4*VALUE_WIDTH-1:0];
                if (pending_keys.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = pending_keys.pop_front();
                    compare_field("public_first", want.public_first, got.public_first);
                    compare_field("public_second", want.public_second, got.public_second);
                    compare_field("shared_first", want.shared_first, got.shared_first);
                    compare_field("shared_second", want.shared_second, got.shared_second);
                end
            end
            outstanding = pending_keys.size();
        end
    end

endmodule

// ===== tb/tb_diffie_hellman_key_generation.sv =====
// Testbench top for the Diffie-Hellman key generation block: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_diffie_hellman_key_generation;

    localparam int VALUE_WIDTH  = 16;
    localparam int TDATA_W      = ((4 * VALUE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 122;
    localparam int CALM_TAIL    = 20;
    // The limit leaves ample margin over the longest item.
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int stall_left   = 0;
    // When set, both the request side and the result side insert random idle bursts.
    logic idle_on = 1'b0;

    diffie_hellman_key_generation #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    dhkg_key_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) key_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The result side drops tready for short random bursts while idling is on.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // The watchdog ends the run once no transaction has happened on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one key request and holds it until the block takes it. tvalid stays high
    // after the transaction, so back-to-back requests never lower and raise it in one step.
    task automatic send_request(input logic [VALUE_WIDTH-1:0] modulus,
                                input logic [VALUE_WIDTH-1:0] generator,
                                input logic [VALUE_WIDTH-1:0] secret_first,
                                input logic [VALUE_WIDTH-1:0] secret_second);
        int gap;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {secret_second, secret_first, generator, modulus};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Random requests: mostly large moduli, some small ones so that reduction wraps often,
    // and now and then a modulus of zero or one. Exponents get random lengths to vary
    // how long the block works on each request.
    task automatic send_random_request();
        logic [VALUE_WIDTH-1:0] modulus;
        logic [VALUE_WIDTH-1:0] generator;
        logic [VALUE_WIDTH-1:0] secret_first;
        logic [VALUE_WIDTH-1:0] secret_second;
        int                     pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            modulus = VALUE_WIDTH'($urandom_range(0, 1));
        end else if (pick < 5) begin
            modulus = VALUE_WIDTH'($urandom_range(2, 64));
        end else begin
            modulus = VALUE_WIDTH'($urandom_range(2, 65535));
        end
        generator     = VALUE_WIDTH'($urandom_range(0, 65535));
        secret_first  = VALUE_WIDTH'($urandom_range(0, 65535) >> $urandom_range(0, 15));
        secret_second = VALUE_WIDTH'($urandom_range(0, 65535) >> $urandom_range(0, 15));
        send_request(modulus, generator, secret_first, secret_second);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on <= 1'b1;

        // Directed requests: a textbook exchange, moduli below two, field extremes,
        // zero exponents, and generators at or above the modulus.
        send_request(16'd23, 16'd5, 16'd6, 16'd15);
        send_request(16'd0, 16'd1234, 16'd5, 16'd7);
        send_request(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(16'd1, 16'd0, 16'd0, 16'd0);
        send_request(16'd2, 16'd3, 16'd1, 16'd1);
        send_request(16'd2, 16'hFFFF, 16'd0, 16'hFFFF);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(16'd65521, 16'd2, 16'hFFFF, 16'hFFFE);
        send_request(16'd65521, 16'd0, 16'd0, 16'd0);
        send_request(16'd65521, 16'd0, 16'd5, 16'd0);
        send_request(16'd97, 16'd500, 16'd0, 16'd33);
        send_request(16'd97, 16'd97, 16'd3, 16'd4);
        send_request(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        send_request(16'd40000, 16'hFFFF, 16'h8000, 16'd1);
        send_request(16'd3, 16'hFFFE, 16'h5555, 16'hAAAA);
        send_request(16'd65521, 16'd65520, 16'd2, 16'd3);
        send_request(16'hFFFF, 16'd1, 16'd12345, 16'd54321);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Idling switches on and off in stretches and stays off for the final part.
            if (n >= RANDOM_ITEMS - CALM_TAIL) begin
                idle_on <= 1'b0;
            end else if (n % 16 == 0) begin
                idle_on <= ($urandom_range(0, 3) != 0);
            end
            send_random_request();
        end
        s_tvalid <= 1'b0;

        // Waiting on the clock lets the checker record the last request before the count is read.
        @(posedge aclk);
        // Wait for every expected key set, then watch a while longer for stray results.
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/dhkg_pkg.sv
sv/dhkg_modmul.sv
sv/diffie_hellman_key_generation.sv
tb/dhkg_key_checker.sv
tb/tb_diffie_hellman_key_generation.sv
